// ===== rtl/ste_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Session table package
// Shared constants, codes and types of the session table engine.
// ----------------------------------------------------------------------------
package ste_pkg;

	localparam int ENTRIES_DEF   = 512;
	localparam int KEY_BITS_DEF  = 64;
	localparam int TIME_BITS_DEF = 32;
	localparam int CNT_W         = 10;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 32;

	typedef enum logic [2:0] {
		CMD_CREATE    = 3'd0,
		CMD_VALIDATE  = 3'd1,
		CMD_GET       = 3'd2,
		CMD_TOUCH     = 3'd3,
		CMD_TERMINATE = 3'd4,
		CMD_REVOKE    = 3'd5,
		CMD_SWEEP     = 3'd6,
		CMD_BAD       = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		SS_ACTIVE     = 2'd0,
		SS_EXPIRED    = 2'd1,
		SS_REVOKED    = 2'd2,
		SS_TERMINATED = 2'd3
	} sess_t;

	localparam logic [1:0] ID_USABLE    = 2'd0;
	localparam logic [1:0] ID_NOT_FOUND = 2'd1;
	localparam logic [1:0] ID_REVOKED   = 2'd2;
	localparam logic [1:0] ID_SUSPENDED = 2'd3;

	localparam logic [3:0] R_OK                 = 4'd0;
	localparam logic [3:0] R_NOT_FOUND          = 4'd1;
	localparam logic [3:0] R_AUTH_FAILED        = 4'd2;
	localparam logic [3:0] R_ID_INVALID         = 4'd3;
	localparam logic [3:0] R_ID_REVOKED         = 4'd4;
	localparam logic [3:0] R_ID_SUSPENDED       = 4'd5;
	localparam logic [3:0] R_LIMIT              = 4'd6;
	localparam logic [3:0] R_EXPIRED            = 4'd7;
	localparam logic [3:0] R_REVOKED            = 4'd8;
	localparam logic [3:0] R_TERMINATED         = 4'd9;
	localparam logic [3:0] R_STATE_INVALID      = 4'd10;
	localparam logic [3:0] R_TRANSITION_INVALID = 4'd11;
	localparam logic [3:0] R_UNAVAILABLE        = 4'd12;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OWNER  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LIFE   = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EVAL,
		ST_WRITE,
		ST_OUT
	} fsm_t;

endpackage
`default_nettype wire

// ===== rtl/ste_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Session table channels
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
interface ste_cmd_if #(
	parameter int KEY_BITS  = 64,
	parameter int TIME_BITS = 32
);
	logic                 valid;
	logic                 ready;
	logic [2:0]           command;
	logic [KEY_BITS-1:0]  session_key;
	logic [KEY_BITS-1:0]  identity_key;
	logic                 auth_verified;
	logic [1:0]           identity_status;
	logic [7:0]           auth_method;
	logic [TIME_BITS-1:0] current_time;
	modport source (output valid, command, session_key, identity_key, auth_verified,
		identity_status, auth_method, current_time, input ready);
	modport sink (input valid, command, session_key, identity_key, auth_verified,
		identity_status, auth_method, current_time, output ready);
endinterface

interface ste_res_if #(
	parameter int KEY_BITS  = 64,
	parameter int TIME_BITS = 32
);
	logic                 valid;
	logic                 ready;
	logic [3:0]           status;
	logic [1:0]           session_status;
	logic [31:0]          record_version;
	logic [TIME_BITS-1:0] created_time;
	logic [TIME_BITS-1:0] last_activity_time;
	logic [TIME_BITS-1:0] idle_expiry;
	logic [TIME_BITS-1:0] absolute_expiry;
	logic [KEY_BITS-1:0]  owner_key;
	logic [7:0]           owner_method;
	logic [9:0]           sessions_used;
	modport source (output valid, status, session_status, record_version, created_time,
		last_activity_time, idle_expiry, absolute_expiry, owner_key, owner_method,
		sessions_used, input ready);
	modport sink (input valid, status, session_status, record_version, created_time,
		last_activity_time, idle_expiry, absolute_expiry, owner_key, owner_method,
		sessions_used, output ready);
endinterface
`default_nettype wire

// ===== rtl/ste_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Session entry memory
// One-port-write, one-port-read entry store with registered read data.
// ----------------------------------------------------------------------------
module ste_mem
	import ste_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF,
	parameter int WIDTH   = 64
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [$clog2(ENTRIES)-1:0] waddr,
	input  wire logic [WIDTH-1:0]           wdata,
	input  wire logic [$clog2(ENTRIES)-1:0] raddr,
	output      logic [WIDTH-1:0]           rdata
);
	logic [WIDTH-1:0] mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/session_table_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Session table engine
// Appends sessions, looks them up by key, updates their state and sweeps expired ones in an entry memory.
// ----------------------------------------------------------------------------
// A command takes longer the more entries are used, since the key search and the owner
// count walk the used entries of the memory one entry per cycle.
// One command is in flight at a time; the next is taken once its result is out.
// Reset clears the fill count and control state and loads the configuration defaults; memory entries need no clearing.
module session_table_engine
	import ste_pkg::*;
#(
	parameter int ENTRIES   = ENTRIES_DEF,
	parameter int KEY_BITS  = KEY_BITS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  cfg_we,
	input wire logic [CFG_IDX_W-1:0]  cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data,
	ste_cmd_if.sink                   cmd,
	ste_res_if.source                 res
);
	localparam int AW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int LW = (CW > 10) ? CW : 10;
	localparam int RW = 2 + 32 + 4 * TIME_BITS + 2 * KEY_BITS + 8;

	typedef struct packed {
		logic [1:0]           st;
		logic [31:0]          rev;
		logic [TIME_BITS-1:0] created;
		logic [TIME_BITS-1:0] last;
		logic [TIME_BITS-1:0] idl;
		logic [TIME_BITS-1:0] life;
		logic [KEY_BITS-1:0]  owner;
		logic [KEY_BITS-1:0]  key;
		logic [7:0]           method;
	} ent_t;

	logic                 en_q;
	logic [9:0]           tot_q, own_q;
	logic [TIME_BITS-1:0] idle_q, life_q;
	logic [CW-1:0]        used_q;

	fsm_t state_q, state_d;
	logic [2:0]           c_cmd_q;
	logic [KEY_BITS-1:0]  c_key_q, c_id_q;
	logic                 c_auth_q;
	logic [1:0]           c_ids_q;
	logic [7:0]           c_meth_q;
	logic [TIME_BITS-1:0] c_now_q;

	logic [CW-1:0] idx_q;
	logic          rd_pend_q;
	logic [AW-1:0] rd_idx_q;
	logic          found_q;
	logic [AW-1:0] slot_q;
	logic [CW-1:0] cnt_q;
	ent_t          rec_q;
	logic [3:0]    stat_q;
	logic          have_q;

	logic          we;
	logic [AW-1:0] waddr;
	ent_t          wdata;
	logic [AW-1:0] raddr;
	logic [RW-1:0] rraw;
	ent_t          rd;

	ste_mem #(.ENTRIES(ENTRIES), .WIDTH(RW)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rraw)
	);
	assign rd = ent_t'(rraw);

	function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
		input logic [TIME_BITS-1:0] b);
		logic [TIME_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q   <= 1'b1;
			tot_q  <= 10'd512;
			own_q  <= 10'd8;
			idle_q <= TIME_BITS'(1800);
			life_q <= TIME_BITS'(86400);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENABLE: en_q   <= cfg_data[0];
				REG_TOTAL:  tot_q  <= cfg_data[9:0];
				REG_OWNER:  own_q  <= cfg_data[9:0];
				REG_IDLE:   idle_q <= TIME_BITS'(cfg_data);
				REG_LIFE:   life_q <= TIME_BITS'(cfg_data);
				default: ;
			endcase
		end
	end

	// Scan: one read issued per cycle, data checked the cycle after.
	logic scan_issue, scan_done, stop_early;
	logic [CW-1:0] limit_eff;
	logic deadline;
	logic [3:0] cre_stat;
	assign scan_issue = (state_q == ST_SCAN) && (idx_q < used_q) && !stop_early;
	assign stop_early = (c_cmd_q != CMD_CREATE) && (c_cmd_q != CMD_SWEEP) && found_q;
	assign scan_done  = (state_q == ST_SCAN) && !rd_pend_q && !scan_issue;
	assign raddr = scan_issue ? idx_q[AW-1:0] : slot_q;
	assign limit_eff = (LW'(tot_q) < LW'(ENTRIES)) ? CW'(tot_q) : CW'(ENTRIES);
	assign deadline = (c_now_q >= rec_q.idl) || (c_now_q >= rec_q.life);

	always_comb begin
		if (!en_q)                  cre_stat = R_UNAVAILABLE;
		else if (!c_auth_q)         cre_stat = R_AUTH_FAILED;
		else if (c_id_q == '0 || c_ids_q == ID_NOT_FOUND) cre_stat = R_ID_INVALID;
		else if (c_ids_q == ID_REVOKED)   cre_stat = R_ID_REVOKED;
		else if (c_ids_q == ID_SUSPENDED) cre_stat = R_ID_SUSPENDED;
		else if (used_q >= limit_eff)     cre_stat = R_LIMIT;
		else if (LW'(cnt_q) >= LW'(own_q)) cre_stat = R_LIMIT;
		else                              cre_stat = R_OK;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (cmd.valid) state_d = ST_SCAN;
			ST_SCAN:  if (scan_done) state_d = ST_EVAL;
			ST_EVAL:  state_d = ST_WRITE;
			ST_WRITE: state_d = ST_OUT;
			ST_OUT:   if (res.ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Sweep writes during scan; other commands write at most once, in ST_WRITE.
	logic sweep_we;
	assign sweep_we = (state_q == ST_SCAN) && rd_pend_q && (c_cmd_q == CMD_SWEEP) &&
		(rd.st == SS_ACTIVE) && ((c_now_q >= rd.idl) || (c_now_q >= rd.life));

	always_comb begin
		we = 1'b0; waddr = slot_q; wdata = rec_q;
		if (sweep_we) begin
			we = 1'b1; waddr = rd_idx_q; wdata = rd;
			wdata.st = SS_EXPIRED; wdata.rev = rd.rev + 32'd1;
		end else if (state_q == ST_WRITE && have_q) begin
			we = 1'b1;
		end
	end

	assign cmd.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			used_q    <= '0;
			rd_pend_q <= 1'b0;
			found_q   <= 1'b0;
			have_q    <= 1'b0;
			idx_q     <= '0;
			cnt_q     <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= '0; cnt_q <= '0; found_q <= 1'b0; have_q <= 1'b0;
					rd_pend_q <= 1'b0;
				end
				ST_SCAN: begin
					rd_pend_q <= scan_issue;
					if (scan_issue) idx_q <= idx_q + CW'(1);
					if (rd_pend_q) begin
						if (!found_q && rd.key == c_key_q) found_q <= 1'b1;
						if (rd.st == SS_ACTIVE && rd.owner == c_id_q) cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_EVAL: begin
					if (c_cmd_q == CMD_CREATE) begin
						have_q <= (cre_stat == R_OK);
						if (cre_stat == R_OK) used_q <= used_q + CW'(1);
					end else if (c_cmd_q != CMD_SWEEP && c_cmd_q != CMD_BAD) begin
						have_q <= found_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				c_cmd_q  <= cmd.command;   c_key_q <= cmd.session_key;
				c_id_q   <= cmd.identity_key; c_auth_q <= cmd.auth_verified;
				c_ids_q  <= cmd.identity_status; c_meth_q <= cmd.auth_method;
				c_now_q  <= cmd.current_time;
			end
			ST_SCAN: begin
				rd_idx_q <= idx_q[AW-1:0];
				if (rd_pend_q && !found_q && rd.key == c_key_q) begin
					slot_q <= rd_idx_q; rec_q <= rd;
				end
			end
			ST_EVAL: begin
				unique case (c_cmd_q)
					CMD_CREATE: begin
						stat_q <= cre_stat;
						slot_q <= used_q[AW-1:0];
						rec_q.st <= SS_ACTIVE; rec_q.rev <= 32'd1;
						rec_q.created <= c_now_q; rec_q.last <= c_now_q;
						rec_q.idl <= sat_add(c_now_q, idle_q);
						rec_q.life <= sat_add(c_now_q, life_q);
						rec_q.owner <= c_id_q; rec_q.key <= c_key_q;
						rec_q.method <= c_meth_q;
					end
					CMD_SWEEP: stat_q <= R_OK;
					CMD_BAD: stat_q <= R_UNAVAILABLE;
					default: begin
						if (!found_q) stat_q <= R_NOT_FOUND;
						else if (c_cmd_q == CMD_VALIDATE) begin
							if (rec_q.st == SS_EXPIRED) stat_q <= R_EXPIRED;
							else if (rec_q.st == SS_REVOKED) stat_q <= R_REVOKED;
							else if (rec_q.st == SS_TERMINATED) stat_q <= R_TERMINATED;
							else if (deadline) begin
								stat_q <= R_EXPIRED; rec_q.st <= SS_EXPIRED;
								rec_q.rev <= rec_q.rev + 32'd1;
							end else if (c_ids_q != ID_USABLE) begin
								rec_q.st <= SS_REVOKED; rec_q.rev <= rec_q.rev + 32'd1;
								stat_q <= (c_ids_q == ID_NOT_FOUND) ? R_ID_INVALID :
									(c_ids_q == ID_REVOKED) ? R_ID_REVOKED : R_ID_SUSPENDED;
							end else stat_q <= R_OK;
						end else if (c_cmd_q == CMD_TOUCH) begin
							if (rec_q.st != SS_ACTIVE) stat_q <= R_STATE_INVALID;
							else begin
								stat_q <= R_OK;
								rec_q.last <= c_now_q;
								rec_q.idl <= sat_add(c_now_q, idle_q);
								rec_q.rev <= rec_q.rev + 32'd1;
							end
						end else if (c_cmd_q == CMD_TERMINATE || c_cmd_q == CMD_REVOKE) begin
							if (rec_q.st == ((c_cmd_q == CMD_TERMINATE) ? SS_TERMINATED
								: SS_REVOKED)) stat_q <= R_OK;
							else if (rec_q.st != SS_ACTIVE) stat_q <= R_TRANSITION_INVALID;
							else if (deadline) begin
								stat_q <= R_TRANSITION_INVALID; rec_q.st <= SS_EXPIRED;
								rec_q.rev <= rec_q.rev + 32'd1;
							end else begin
								stat_q <= R_OK;
								rec_q.st <= (c_cmd_q == CMD_TERMINATE) ? SS_TERMINATED
									: SS_REVOKED;
								rec_q.rev <= rec_q.rev + 32'd1;
							end
						end else stat_q <= R_OK;
					end
				endcase
			end
			default: ;
		endcase
	end

	assign res.valid              = (state_q == ST_OUT);
	assign res.status             = stat_q;
	assign res.session_status     = have_q ? rec_q.st : 2'd0;
	assign res.record_version     = have_q ? rec_q.rev : '0;
	assign res.created_time       = have_q ? rec_q.created : '0;
	assign res.last_activity_time = have_q ? rec_q.last : '0;
	assign res.idle_expiry        = have_q ? rec_q.idl : '0;
	assign res.absolute_expiry    = have_q ? rec_q.life : '0;
	assign res.owner_key          = have_q ? rec_q.owner : '0;
	assign res.owner_method       = have_q ? rec_q.method : '0;
	assign res.sessions_used      = 10'(used_q);
endmodule
`default_nettype wire
